[design/attitude_error_hysteresis_deadband_assert.svh]
// Assertion macros shared by the deadband block.
`ifndef ATTITUDE_ERROR_HYSTERESIS_DEADBAND_ASSERT_SVH
`define ATTITUDE_ERROR_HYSTERESIS_DEADBAND_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define AEHD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define AEHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/aehd_pkg.sv]
// ----------------------------------------------------------------------------
// aehd_pkg
// Types, constants and the arctangent table of the attitude deadband block.
// ----------------------------------------------------------------------------
`default_nettype none
package aehd_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicIdxW  = 5;

  localparam logic CfgInner = 1'b0;
  localparam logic CfgOuter = 1'b1;

  // Datapath commands
  typedef struct packed {
    logic load;       // capture sample
    logic rsq_start;  // start square root of sigma sum
    logic cor_init;   // seed CORDIC from the root
    logic cor_step;   // one CORDIC rotation
    logic esq_start;  // start the combined error root
    logic finish;     // decide and register the result
  } aehd_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } aehd_sts_t;

  typedef struct packed {
    logic signed [15:0] att_err_x;
    logic signed [15:0] att_err_y;
    logic signed [15:0] att_err_z;
    logic signed [15:0] rate_err_x;
    logic signed [15:0] rate_err_y;
    logic signed [15:0] rate_err_z;
  } aehd_in_t;

  typedef struct packed {
    logic signed [15:0] out_att_x;
    logic signed [15:0] out_att_y;
    logic signed [15:0] out_att_z;
    logic signed [15:0] out_rate_x;
    logic signed [15:0] out_rate_y;
    logic signed [15:0] out_rate_z;
    logic               control_off;
    logic        [15:0] combined_error;
  } aehd_out_t;

  function automatic logic signed [33:0] atan_entry(input logic [CordicIdxW-1:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0:  r = 34'sh03243F6A8;
        5'd1:  r = 34'sh01DAC6705;
        5'd2:  r = 34'sh00FADBAFC;
        5'd3:  r = 34'sh007F56EA6;
        5'd4:  r = 34'sh003FEAB76;
        5'd5:  r = 34'sh001FFD55B;
        5'd6:  r = 34'sh000FFFAAA;
        5'd7:  r = 34'sh0007FFF55;
        5'd8:  r = 34'sh0003FFFEA;
        5'd9:  r = 34'sh0001FFFFD;
        5'd10: r = 34'sh0000FFFFF;
        5'd11: r = 34'sh00007FFFF;
        5'd12: r = 34'sh00003FFFF;
        5'd13: r = 34'sh00001FFFF;
        5'd14: r = 34'sh00000FFFF;
        5'd15: r = 34'sh000007FFF;
        5'd16: r = 34'sh000003FFF;
        5'd17: r = 34'sh000001FFF;
        5'd18: r = 34'sh000000FFF;
        5'd19: r = 34'sh0000007FF;
        5'd20: r = 34'sh0000003FF;
        5'd21: r = 34'sh0000001FF;
        5'd22: r = 34'sh0000000FF;
        5'd23: r = 34'sh00000007F;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[design/aehd_isqrt.sv]
// ----------------------------------------------------------------------------
// aehd_isqrt
// Digit-by-digit integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module aehd_isqrt import aehd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic      [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [64:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[63:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[design/aehd_datapath.sv]
// ----------------------------------------------------------------------------
// aehd_datapath
// Sample registers, shared square root, CORDIC unit and the deadband decision.
// ----------------------------------------------------------------------------
`default_nettype none
module aehd_datapath import aehd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire aehd_cmd_t        cmd,
  output aehd_sts_t             sts,
  input  wire aehd_in_t         in_data,
  input  wire logic      [15:0] inner_threshold,
  input  wire logic      [15:0] outer_threshold,
  output aehd_out_t             res_data
);

  aehd_in_t           smp;
  logic               was_off;
  logic        [63:0] rad;
  logic               sq_start;
  logic               sq_done;
  logic        [31:0] sq_root;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [33:0] cz;
  logic [CordicIdxW-1:0] ci;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] zc;
  logic        [31:0] ssq;
  logic        [31:0] att24;
  logic        [63:0] rsq;
  logic        [63:0] esq;
  logic        [31:0] emag;
  logic        [15:0] e;
  logic               off;

  assign sts.sqrt_done = sq_done;

  // Squared terms; each multiply is 16x16 or 32x32 and feeds a register.
  logic [31:0] sq_ax, sq_ay, sq_az, sq_rx, sq_ry, sq_rz;
  assign sq_ax = 32'(smp.att_err_x * smp.att_err_x);
  assign sq_ay = 32'(smp.att_err_y * smp.att_err_y);
  assign sq_az = 32'(smp.att_err_z * smp.att_err_z);
  assign sq_rx = 32'(smp.rate_err_x * smp.rate_err_x);
  assign sq_ry = 32'(smp.rate_err_y * smp.rate_err_y);
  assign sq_rz = 32'(smp.rate_err_z * smp.rate_err_z);

  assign ssq = sq_ax + sq_ay + sq_az;

  always_ff @(posedge clk) begin
    rsq <= ({32'd0, sq_rx} << 24) + ({32'd0, sq_ry} << 24) + ({32'd0, sq_rz} << 24);
  end

  assign zc    = (cz < 0) ? '0 : cz;
  always_ff @(posedge clk) begin
    att24 <= {2'b00, zc[33:4]};
  end
  assign esq = 64'(att24 * att24) + rsq;

  assign sq_start = cmd.rsq_start | cmd.esq_start;
  assign rad      = cmd.esq_start ? esq : {ssq, 32'd0};

  aehd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign xs = cx >>> ci;
  assign ys = cy >>> ci;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= in_data;
    end
    if (cmd.cor_init) begin
      cx <= 34'sh040000000;
      cy <= $signed({2'b00, sq_root});
      cz <= '0;
      ci <= '0;
    end else if (cmd.cor_step) begin
      if (cy >= 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_entry(ci);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_entry(ci);
      end
      ci <= ci + 1'b1;
    end
  end

  assign emag = sq_root;
  assign e    = (emag[31:12] > 20'hFFFF) ? 16'hFFFF : emag[27:12];
  assign off  = (e < outer_threshold) &&
                ((e < inner_threshold) || ((e > inner_threshold) && was_off));

  always_ff @(posedge clk) begin
    if (rst) begin
      was_off <= 1'b0;
    end else if (cmd.finish) begin
      was_off <= off;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_data.out_att_x      <= off ? '0 : smp.att_err_x;
      res_data.out_att_y      <= off ? '0 : smp.att_err_y;
      res_data.out_att_z      <= off ? '0 : smp.att_err_z;
      res_data.out_rate_x     <= off ? '0 : smp.rate_err_x;
      res_data.out_rate_y     <= off ? '0 : smp.rate_err_y;
      res_data.out_rate_z     <= off ? '0 : smp.rate_err_z;
      res_data.control_off    <= off;
      res_data.combined_error <= e;
    end
  end

endmodule
`default_nettype wire

[design/aehd_ctrl.sv]
// ----------------------------------------------------------------------------
// aehd_ctrl
// Sequencer: sums, sigma root, CORDIC, error root, decision, output hold.
// ----------------------------------------------------------------------------
`default_nettype none
module aehd_ctrl import aehd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output aehd_cmd_t      cmd,
  input  wire aehd_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_SRT1 = 3'd2;
  localparam logic [2:0] S_COR  = 3'd3;
  localparam logic [2:0] S_ATT  = 3'd4;
  localparam logic [2:0] S_ESQ  = 3'd5;
  localparam logic [2:0] S_SRT2 = 3'd6;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CordicIdxW-1:0] cnt;
  logic                  sq_started;

  // Accept a new request while idle, once the result slot is free or being drained.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.rsq_start = 1'b1;
        state_next    = S_SRT1;
      end
      S_SRT1: if (sts.sqrt_done) begin
        cmd.cor_init = 1'b1;
        state_next   = S_COR;
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        if (cnt == CordicIdxW'(CordicSteps - 1)) state_next = S_ATT;
      end
      S_ATT: state_next = S_ESQ;
      S_ESQ: begin
        cmd.esq_start = 1'b1;
        state_next    = S_SRT2;
      end
      S_SRT2: if (sts.sqrt_done) begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      sq_started <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.cor_init) cnt <= '0;
      else if (cmd.cor_step) cnt <= cnt + 1'b1;
      sq_started <= cmd.rsq_start | cmd.esq_start;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`include "attitude_error_hysteresis_deadband_assert.svh"

  `AEHD_ASSERT_IMP(a_load_needs_free, clk, rst, cmd.load, !out_valid || out_ready, "load over pending result")
  `AEHD_ASSERT_NEXT(a_finish_valid, clk, rst, cmd.finish, out_valid, "finish without result")
  `AEHD_ASSERT_IMP(a_no_done_early, clk, rst, sq_started, !sts.sqrt_done, "root done at start")

endmodule
`default_nettype wire

[design/attitude_error_hysteresis_deadband.sv]
// ----------------------------------------------------------------------------
// attitude_error_hysteresis_deadband
// Combined attitude/rate error magnitude with two-level hysteresis deadband.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready, payload in_data
//  out     | output    | out_valid / out_ready, payload out_data
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// A request is taken only while no earlier request is in flight; each one takes
// two 32-step passes of the shared square root unit, 16 CORDIC rotations and
// the control states around them.
// Reset clears the thresholds to zero and the hysteresis flag to control on.
// A result waits in the output register; the next request is taken as it drains.
// ----------------------------------------------------------------------------
`default_nettype none
module attitude_error_hysteresis_deadband import aehd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire aehd_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output aehd_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] inner_threshold;
  logic [15:0] outer_threshold;
  aehd_cmd_t   cmd;
  aehd_sts_t   sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_threshold <= '0;
      outer_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgInner: inner_threshold <= cfg_data;
        CfgOuter: outer_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  aehd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  aehd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_data         (in_data),
    .inner_threshold (inner_threshold),
    .outer_threshold (outer_threshold),
    .res_data        (out_data)
  );

endmodule
`default_nettype wire

[tb/attitude_error_hysteresis_deadband_checker.sv]
// ----------------------------------------------------------------------------
// attitude_error_hysteresis_deadband_checker
// Watches the request and result channels and the register writes, predicts
// each result from the combined error and the hysteresis flag, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module attitude_error_hysteresis_deadband_checker import aehd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  aehd_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  aehd_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          results_seen,
  output int          offs_seen
);

  logic [15:0] inner_lvl;
  logic [15:0] outer_lvl;
  logic        ctrl_was_off;
  aehd_out_t   expected_results[$];

  localparam longint AtanQ30[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    begin
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    end
  endfunction

  function automatic longint mrp_angle(input longint t);
    longint x, y, z, xs, ys;
    begin
      x = 64'sd1 << 30;
      y = t;
      z = 0;
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + AtanQ30[i];
        end else begin
          x = x - ys; y = y + xs; z = z - AtanQ30[i];
        end
      end
      return (z < 0) ? 0 : z;
    end
  endfunction

  function automatic logic [15:0] error_magnitude(input aehd_in_t s);
    longint unsigned ssq, rsq, e24;
    longint a, att24;
    begin
      ssq = longint'(s.att_err_x) * s.att_err_x + longint'(s.att_err_y) * s.att_err_y
          + longint'(s.att_err_z) * s.att_err_z;
      a = mrp_angle(longint'(int_root(ssq << 32)));
      att24 = (4 * a) >>> 6;
      rsq = ((longint'(s.rate_err_x) * s.rate_err_x) << 24)
          + ((longint'(s.rate_err_y) * s.rate_err_y) << 24)
          + ((longint'(s.rate_err_z) * s.rate_err_z) << 24);
      e24 = int_root(longint'(att24 * att24) + rsq);
      e24 = e24 >> 12;
      return (e24 > 64'hFFFF) ? 16'hFFFF : e24[15:0];
    end
  endfunction

  function automatic aehd_out_t deadband_result(input aehd_in_t s);
    aehd_out_t r;
    logic [15:0] e;
    logic off;
    begin
      e = error_magnitude(s);
      off = (e < outer_lvl) && ((e < inner_lvl) || (e > inner_lvl && ctrl_was_off));
      ctrl_was_off = off;
      r.out_att_x  = off ? '0 : s.att_err_x;
      r.out_att_y  = off ? '0 : s.att_err_y;
      r.out_att_z  = off ? '0 : s.att_err_z;
      r.out_rate_x = off ? '0 : s.rate_err_x;
      r.out_rate_y = off ? '0 : s.rate_err_y;
      r.out_rate_z = off ? '0 : s.rate_err_z;
      r.control_off = off;
      r.combined_error = e;
      return r;
    end
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    aehd_out_t want;
    if (rst) begin
      inner_lvl <= '0;
      outer_lvl <= '0;
      ctrl_was_off = 1'b0;
      mismatches <= 0;
      results_seen <= 0;
      offs_seen <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgInner) inner_lvl <= cfg_data;
        else outer_lvl <= cfg_data;
      end
      if (in_valid && in_ready) expected_results.push_back(deadband_result(in_data));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        offs_seen <= offs_seen + out_data.control_off;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            if (mismatches < 10)
              $display("result %0d: expected att %h %h %h rate %h %h %h off %b e %h, got att %h %h %h rate %h %h %h off %b e %h",
                results_seen, want.out_att_x, want.out_att_y, want.out_att_z,
                want.out_rate_x, want.out_rate_y, want.out_rate_z, want.control_off,
                want.combined_error, out_data.out_att_x, out_data.out_att_y,
                out_data.out_att_z, out_data.out_rate_x, out_data.out_rate_y,
                out_data.out_rate_z, out_data.control_off, out_data.combined_error);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

[tb/attitude_error_hysteresis_deadband_tb.sv]
// ----------------------------------------------------------------------------
// attitude_error_hysteresis_deadband_tb
// Drives directed and random attitude-error requests through several
// threshold settings with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module attitude_error_hysteresis_deadband_tb import aehd_pkg::*; ();

  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  aehd_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  aehd_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CfgInner;
  logic [15:0] cfg_data = '0;
  int          mismatches, pending, results_seen, offs_seen;
  int          idle_cycles = 0;
  int          sent = 0;
  int          out_wait = 0;
  bit          hold_off = 1'b0;

  always #1 clk = ~clk;

  attitude_error_hysteresis_deadband DUT (.*);

  attitude_error_hysteresis_deadband_checker checker_i (.*);

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(input aehd_in_t s);
    repeat ($urandom_range(0, 15)) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    sent++;
  endtask

  // Sample near a target error: small MRP and rate picked so e lands around lvl.
  function automatic aehd_in_t near_level(input logic [15:0] lvl);
    aehd_in_t s;
    int r;
    begin
      s = '0;
      r = int'(lvl) + $urandom_range(0, 400) - 200;
      if (r < 0) r = 0;
      if (r > 32767) r = 32767;
      s.rate_err_x = $urandom_range(0, 1) ? 16'(-r) : 16'(r);
      s.rate_err_y = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom_range(0, 60)) - 16'sd30;
      s.att_err_z  = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom_range(0, 40)) - 16'sd20;
      return s;
    end
  endfunction

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Receiver: wait a drawn number of cycles per result, with one long hold-off.
  always @(negedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (out_wait == 0) out_ready <= 1'b1;
      else out_wait <= out_wait - 1;
    end else if (out_ready && !out_valid) begin
      out_ready <= 1'b0;
      out_wait <= $urandom_range(0, 15);
    end
  end

  initial begin
    @(posedge clk);
    wait (sent == 200);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("attitude_error_hysteresis_deadband: mismatch");
      $finish;
    end
  end

  initial begin
    aehd_in_t s;
    logic [15:0] levels[5][2];
    levels = '{'{16'd0, 16'd0}, '{16'd3000, 16'd6000}, '{16'd8000, 16'd8000},
               '{16'hFFFF, 16'hFFFF}, '{16'd20000, 16'd12000}};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes with default thresholds, then deadband edges
    s = '0; send(s);
    s = {6{16'sh7FFF}}; send(s);
    s = {6{16'sh8000}}; send(s);
    s = '0; s.att_err_x = 16'sh7FFF; send(s);
    s = '0; s.rate_err_z = 16'sh8000; send(s);
    s = {16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}; send(s);
    drain();
    write_reg(CfgInner, 16'd4096);
    write_reg(CfgOuter, 16'd8192);
    s = '0; send(s);                                  // below inner: off
    s = '0; s.rate_err_x = 16'sd6000; send(s);        // inside band, was off: off
    s = '0; s.rate_err_x = 16'sd4096; send(s);        // equal inner: on
    s = '0; s.rate_err_x = 16'sd6000; send(s);        // inside band, was on: on
    s = '0; s.rate_err_x = 16'sd8192; send(s);        // at outer: on
    s = '0; s.rate_err_y = 16'sd100; send(s);         // off again
    s = '0; s.rate_err_y = -16'sd9000; send(s);       // above outer: on
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgInner, levels[ph][0]);
      write_reg(CfgOuter, levels[ph][1]);
      for (int n = 0; n < 148; n++) begin
        case ($urandom_range(0, 3))
          0: s = aehd_in_t'({$urandom, $urandom, $urandom});
          1: s = near_level(levels[ph][$urandom_range(0, 1)]);
          2: s = near_level($urandom_range(0, 16000));
          default: begin
            s = '0;
            s.att_err_x = 16'($urandom_range(0, 4000)) - 16'sd2000;
            s.att_err_y = 16'($urandom_range(0, 4000)) - 16'sd2000;
            s.rate_err_z = 16'($urandom_range(0, 4000)) - 16'sd2000;
          end
        endcase
        send(s);
      end
      drain();
    end

    $display("%0d requests, %0d results, %0d with control off, 5 threshold settings",
             sent, results_seen, offs_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("attitude_error_hysteresis_deadband: match");
    end else begin
      $display("attitude_error_hysteresis_deadband: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/aehd_pkg.sv
design/aehd_isqrt.sv
design/aehd_datapath.sv
design/aehd_ctrl.sv
design/attitude_error_hysteresis_deadband.sv
tb/attitude_error_hysteresis_deadband_checker.sv
tb/attitude_error_hysteresis_deadband_tb.sv
